// File: rtl/isosceles_apex_point_macros.svh
// assertion helpers for the apex point block
`ifndef ISOSCELES_APEX_POINT_MACROS_SVH
`define ISOSCELES_APEX_POINT_MACROS_SVH
`ifndef SYNTHESIS
`define APX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apex point check failed");
`define APX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apex point check failed");
`else
`define APX_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define APX_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/apx_pkg.sv
package apx_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_COINCIDE = 2'd1;
  localparam status_t ST_SHORT    = 2'd2;
  localparam status_t ST_SAT      = 2'd3;

  typedef struct packed {
    logic coincide;
    logic too_short;
  } flags_t;

  typedef struct packed {
    flags_t fl;
    logic   neg_x;
    logic   neg_y;
    logic   ovf_x;
    logic   ovf_y;
  } fin_t;

endpackage

// File: rtl/apex_in_if.sv
interface apex_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] second_x;
  logic signed [W-1:0] second_y;
  logic        [W-1:0] side_length;

  modport source(output valid, first_x, first_y, second_x, second_y, side_length,
                 input ready);
  modport sink(input valid, first_x, first_y, second_x, second_y, side_length,
               output ready);
endinterface

// File: rtl/apex_out_if.sv
interface apex_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] apex_x;
  logic signed [W-1:0] apex_y;
  logic        [1:0]   status;

  modport source(output valid, apex_x, apex_y, status, input ready);
  modport sink(input valid, apex_x, apex_y, status, output ready);
endinterface

// File: rtl/isosceles_apex_point.sv
// Apex of the isosceles triangle left of the base P1->P2 with the given side
// length. Fully pipelined: a new item may enter every cycle unless a finished
// result waits untaken. Most of the stages are those of the two digit-by-digit
// square roots (COORD_WIDTH+1 stages, run side by side) and the restoring long
// division (COORD_WIDTH stages, x and y side by side). All stages advance
// together: while a finished result is not taken, the whole pipeline holds and
// input ready is low. Coordinates are any signed fixed-point format; the
// fraction position does not change any result bit.
`include "isosceles_apex_point_macros.svh"

module isosceles_apex_point #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  apex_in_if.sink     in_ch,
  apex_out_if.source  out_ch
);
  import apx_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int R   = W + 1;
  localparam int ML  = R / 2;
  localparam int MH  = R - ML;
  localparam int PW  = 2 * W + 4;
  localparam int DW  = W + 2;
  localparam int L   = 13 + R + W;
  localparam int SBW = 4 * R;
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  logic         en;
  logic [L-1:0] vld;

  assign en           = !vld[L-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], in_ch.valid};
    end
  end

  // differences and sums
  logic signed [W:0] a_dx, a_dy, a_sx, a_sy;
  logic [W-1:0]      a_s;

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= {in_ch.second_x[W-1], in_ch.second_x} - {in_ch.first_x[W-1], in_ch.first_x};
      a_dy <= {in_ch.second_y[W-1], in_ch.second_y} - {in_ch.first_y[W-1], in_ch.first_y};
      a_sx <= {in_ch.second_x[W-1], in_ch.second_x} + {in_ch.first_x[W-1], in_ch.first_x};
      a_sy <= {in_ch.second_y[W-1], in_ch.second_y} + {in_ch.first_y[W-1], in_ch.first_y};
      a_s  <= in_ch.side_length;
    end
  end

  // magnitudes
  logic signed [W:0] b_dx, b_dy, b_sx, b_sy;
  logic [W:0]        b_mdx, b_mdy, b_ms;

  always_ff @(posedge clk) begin
    if (en) begin
      b_mdx <= a_dx[W] ? -a_dx : a_dx;
      b_mdy <= a_dy[W] ? -a_dy : a_dy;
      b_ms  <= {1'b0, a_s};
      b_dx  <= a_dx;
      b_dy  <= a_dy;
      b_sx  <= a_sx;
      b_sy  <= a_sy;
    end
  end

  // squares as two half products each
  logic signed [W:0] c_dx, c_dy, c_sx, c_sy;
  logic [R+ML-1:0]   c_dxl, c_dyl, c_sl;
  logic [R+MH-1:0]   c_dxh, c_dyh, c_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      c_dxl <= (R+ML)'(b_mdx) * (R+ML)'(b_mdx[ML-1:0]);
      c_dxh <= (R+MH)'(b_mdx) * (R+MH)'(b_mdx[R-1:ML]);
      c_dyl <= (R+ML)'(b_mdy) * (R+ML)'(b_mdy[ML-1:0]);
      c_dyh <= (R+MH)'(b_mdy) * (R+MH)'(b_mdy[R-1:ML]);
      c_sl  <= (R+ML)'(b_ms) * (R+ML)'(b_ms[ML-1:0]);
      c_sh  <= (R+MH)'(b_ms) * (R+MH)'(b_ms[R-1:ML]);
      c_dx  <= b_dx;
      c_dy  <= b_dy;
      c_sx  <= b_sx;
      c_sy  <= b_sy;
    end
  end

  logic signed [W:0] d_dx, d_dy, d_sx, d_sy;
  logic [2*R-1:0]    d_dx2, d_dy2, d_s2;

  always_ff @(posedge clk) begin
    if (en) begin
      d_dx2 <= (2*R)'(c_dxl) + ((2*R)'(c_dxh) << ML);
      d_dy2 <= (2*R)'(c_dyl) + ((2*R)'(c_dyh) << ML);
      d_s2  <= (2*R)'(c_sl) + ((2*R)'(c_sh) << ML);
      d_dx  <= c_dx;
      d_dy  <= c_dy;
      d_sx  <= c_sx;
      d_sy  <= c_sy;
    end
  end

  logic signed [W:0] e_dx, e_dy, e_sx, e_sy;
  logic [2*R-1:0]    e_d2, e_s4;

  always_ff @(posedge clk) begin
    if (en) begin
      e_d2 <= d_dx2 + d_dy2;
      e_s4 <= d_s2 << 2;
      e_dx <= d_dx;
      e_dy <= d_dy;
      e_sx <= d_sx;
      e_sy <= d_sy;
    end
  end

  // error checks and radicand of twice the height
  logic signed [W:0] f_dx, f_dy, f_sx, f_sy;
  logic [2*R-1:0]    f_rad, f_d2;
  flags_t            f_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      f_fl.coincide  <= e_d2 == '0;
      f_fl.too_short <= e_s4 < e_d2;
      f_rad          <= (e_s4 < e_d2) ? '0 : e_s4 - e_d2;
      f_d2           <= e_d2;
      f_dx           <= e_dx;
      f_dy           <= e_dy;
      f_sx           <= e_sx;
      f_sy           <= e_sy;
    end
  end

  logic [R-1:0] hq, dq;

  apx_sqrt_pipe #(.N(R)) u_sqrt_h (
    .clk  (clk),
    .en   (en),
    .rad  (f_rad),
    .root (hq)
  );

  apx_sqrt_pipe #(.N(R)) u_sqrt_d (
    .clk  (clk),
    .en   (en),
    .rad  (f_d2),
    .root (dq)
  );

  logic [SBW-1:0] sq_sb [R];
  flags_t         sq_fl [R];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sb[0] <= {f_dx, f_dy, f_sx, f_sy};
      sq_fl[0] <= f_fl;
      for (int k = 1; k < R; k++) begin
        sq_sb[k] <= sq_sb[k-1];
        sq_fl[k] <= sq_fl[k-1];
      end
    end
  end

  logic signed [W:0] t_dx, t_dy, t_sx, t_sy;

  assign t_dx = sq_sb[R-1][4*R-1 -: R];
  assign t_dy = sq_sb[R-1][3*R-1 -: R];
  assign t_sx = sq_sb[R-1][2*R-1 -: R];
  assign t_sy = sq_sb[R-1][R-1:0];

  // cross products, split on the root operand
  logic signed [R+ML:0] g_sxdl, g_sydl, g_dyhl, g_dxhl;
  logic signed [R+MH:0] g_sxdh, g_sydh, g_dyhh, g_dxhh;
  logic [R-1:0]         g_dq;
  flags_t               g_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      g_sxdl <= (R+ML+1)'(t_sx) * (R+ML+1)'($signed({1'b0, dq[ML-1:0]}));
      g_sxdh <= (R+MH+1)'(t_sx) * (R+MH+1)'($signed({1'b0, dq[R-1:ML]}));
      g_sydl <= (R+ML+1)'(t_sy) * (R+ML+1)'($signed({1'b0, dq[ML-1:0]}));
      g_sydh <= (R+MH+1)'(t_sy) * (R+MH+1)'($signed({1'b0, dq[R-1:ML]}));
      g_dyhl <= (R+ML+1)'(t_dy) * (R+ML+1)'($signed({1'b0, hq[ML-1:0]}));
      g_dyhh <= (R+MH+1)'(t_dy) * (R+MH+1)'($signed({1'b0, hq[R-1:ML]}));
      g_dxhl <= (R+ML+1)'(t_dx) * (R+ML+1)'($signed({1'b0, hq[ML-1:0]}));
      g_dxhh <= (R+MH+1)'(t_dx) * (R+MH+1)'($signed({1'b0, hq[R-1:ML]}));
      g_dq   <= dq;
      g_fl   <= sq_fl[R-1];
    end
  end

  logic signed [PW-1:0] h_sxdq, h_sydq, h_dyhq, h_dxhq;
  logic [R-1:0]         h_dq;
  flags_t               h_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      h_sxdq <= PW'(g_sxdl) + (PW'(g_sxdh) <<< ML);
      h_sydq <= PW'(g_sydl) + (PW'(g_sydh) <<< ML);
      h_dyhq <= PW'(g_dyhl) + (PW'(g_dyhh) <<< ML);
      h_dxhq <= PW'(g_dxhl) + (PW'(g_dxhh) <<< ML);
      h_dq   <= g_dq;
      h_fl   <= g_fl;
    end
  end

  logic signed [PW-1:0] i_nx, i_ny;
  logic [R-1:0]         i_dq;
  flags_t               i_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      i_nx <= h_sxdq - h_dyhq;
      i_ny <= h_sydq + h_dxhq;
      i_dq <= h_dq;
      i_fl <= h_fl;
    end
  end

  logic [PW-1:0] j_mx, j_my;
  logic          j_negx, j_negy;
  logic [R-1:0]  j_dq;
  flags_t        j_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      j_negx <= i_nx[PW-1];
      j_negy <= i_ny[PW-1];
      j_mx   <= i_nx[PW-1] ? -i_nx : i_nx;
      j_my   <= i_ny[PW-1] ? -i_ny : i_ny;
      j_dq   <= i_dq;
      j_fl   <= i_fl;
    end
  end

  // add half the divisor for round to nearest
  logic [PW-1:0] k_numx, k_numy;
  logic [DW-1:0] k_div;
  logic          k_negx, k_negy;
  flags_t        k_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      k_numx <= j_mx + PW'(j_dq);
      k_numy <= j_my + PW'(j_dq);
      k_div  <= {j_dq, 1'b0};
      k_negx <= j_negx;
      k_negy <= j_negy;
      k_fl   <= j_fl;
    end
  end

  // quotient wider than COORD_WIDTH bits always saturates
  logic [DW-1:0] l_hix, l_hiy, l_div;
  logic [W-1:0]  l_lox, l_loy;
  fin_t          l_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      l_fin.ovf_x <= k_numx[PW-1:W] >= (PW-W)'(k_div);
      l_fin.ovf_y <= k_numy[PW-1:W] >= (PW-W)'(k_div);
      l_fin.neg_x <= k_negx;
      l_fin.neg_y <= k_negy;
      l_fin.fl    <= k_fl;
      l_hix       <= k_numx[W+DW-1:W];
      l_hiy       <= k_numy[W+DW-1:W];
      l_lox       <= k_numx[W-1:0];
      l_loy       <= k_numy[W-1:0];
      l_div       <= k_div;
    end
  end

  logic [W-1:0] qx, qy;

  apx_div_pipe #(.N(W), .DW(DW)) u_div_x (
    .clk  (clk),
    .en   (en),
    .hi   (l_hix),
    .lo   (l_lox),
    .div  (l_div),
    .quot (qx)
  );

  apx_div_pipe #(.N(W), .DW(DW)) u_div_y (
    .clk  (clk),
    .en   (en),
    .hi   (l_hiy),
    .lo   (l_loy),
    .div  (l_div),
    .quot (qy)
  );

  fin_t dv_fin [W];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_fin[0] <= l_fin;
      for (int k = 1; k < W; k++) begin
        dv_fin[k] <= dv_fin[k-1];
      end
    end
  end

  // sign, clamp and status
  fin_t         fin;
  logic         sat_x, sat_y;
  logic [W-1:0] val_x, val_y;

  always_comb begin
    fin   = dv_fin[W-1];
    sat_x = fin.ovf_x || (fin.neg_x ? (qx[W-1] && (|qx[W-2:0])) : qx[W-1]);
    sat_y = fin.ovf_y || (fin.neg_y ? (qy[W-1] && (|qy[W-2:0])) : qy[W-1]);
    val_x = sat_x ? (fin.neg_x ? MIN_V : MAX_V) : (fin.neg_x ? -qx : qx);
    val_y = sat_y ? (fin.neg_y ? MIN_V : MAX_V) : (fin.neg_y ? -qy : qy);
  end

  logic [W-1:0] o_x, o_y;
  status_t      o_st;

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin.fl.coincide) begin
        o_st <= ST_COINCIDE;
        o_x  <= '0;
        o_y  <= '0;
      end else if (fin.fl.too_short) begin
        o_st <= ST_SHORT;
        o_x  <= '0;
        o_y  <= '0;
      end else begin
        o_st <= (sat_x || sat_y) ? ST_SAT : ST_OK;
        o_x  <= val_x;
        o_y  <= val_y;
      end
    end
  end

  assign out_ch.apex_x = o_x;
  assign out_ch.apex_y = o_y;
  assign out_ch.status = o_st;

  `APX_ASSERT_IMP(a_err_zero, clk, rst, out_ch.valid && (out_ch.status == ST_COINCIDE || out_ch.status == ST_SHORT), out_ch.apex_x == '0 && out_ch.apex_y == '0)
  `APX_ASSERT_IMP(a_sat_bound, clk, rst, out_ch.valid && out_ch.status == ST_SAT, o_x == MAX_V || o_x == MIN_V || o_y == MAX_V || o_y == MIN_V)
  `APX_ASSERT_NXT(a_hold_valid, clk, rst, !en, $stable(vld))
  `APX_ASSERT_NXT(a_enter, clk, rst, in_ch.valid && in_ch.ready, vld[0])

endmodule

// File: rtl/apx_sqrt_pipe.sv
module apx_sqrt_pipe #(
  parameter int N = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] rad,
  output logic [N-1:0]   root
);

  logic [N+1:0]   rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] rad_q  [N];

  // one result bit per stage, two radicand bits brought down each time
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [N+1:0]   rem_i;
    logic [N-1:0]   root_i;
    logic [2*N-1:0] rad_i;
    logic [N+3:0]   part;
    logic [N+3:0]   trial;
    logic [N+3:0]   diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_next
      assign rem_i  = rem_q[j-1];
      assign root_i = root_q[j-1];
      assign rad_i  = rad_q[j-1];
    end

    assign part  = {rem_i, rad_i[2*N-1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge    = part >= trial;
    assign diff  = part - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? diff[N+1:0] : part[N+1:0];
        root_q[j] <= {root_i[N-2:0], ge};
        rad_q[j]  <= rad_i << 2;
      end
    end
  end

  assign root = root_q[N-1];

endmodule

// File: rtl/apx_div_pipe.sv
module apx_div_pipe #(
  parameter int N  = 32,
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] hi,
  input  logic [N-1:0]  lo,
  input  logic [DW-1:0] div,
  output logic [N-1:0]  quot
);

  logic [DW-1:0] rem_q [N];
  logic [N-1:0]  lo_q  [N];
  logic [N-1:0]  q_q   [N];
  logic [DW-1:0] div_q [N];

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [DW-1:0] rem_i;
    logic [N-1:0]  lo_i;
    logic [N-1:0]  q_i;
    logic [DW-1:0] div_i;
    logic [DW:0]   part;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_i = hi;
      assign lo_i  = lo;
      assign q_i   = '0;
      assign div_i = div;
    end else begin : g_next
      assign rem_i = rem_q[j-1];
      assign lo_i  = lo_q[j-1];
      assign q_i   = q_q[j-1];
      assign div_i = div_q[j-1];
    end

    assign part = {rem_i, lo_i[N-1]};
    assign ge   = part >= {1'b0, div_i};
    assign diff = part - {1'b0, div_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? diff[DW-1:0] : part[DW-1:0];
        lo_q[j]  <= lo_i << 1;
        q_q[j]   <= {q_i[N-2:0], ge};
        div_q[j] <= div_i;
      end
    end
  end

  assign quot = q_q[N-1];

endmodule
